// ===== hdl/bmh_pkg.sv =====
package bmh_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_BITS = 32;
	localparam int ADDR_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int ID_BITS = 16;
	localparam int ENTRY_BITS = ID_BITS + KEY_BITS;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_DECREASE = 2'd2,
		CMD_EXTRACT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_SEARCH_CHK,
		S_UP_RD,
		S_UP_CMP,
		S_EXT_RD,
		S_EXT_WR,
		S_DN_RD_L,
		S_DN_RD_R,
		S_DN_CMP,
		S_BUILD_NEXT,
		S_BUILD_LD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [KEY_BITS-1:0] key;
	} entry_t;

endpackage

// ===== hdl/binary_min_heap_priority_queue.sv =====
// Min-heap priority queue of (node, distance) entries in one single-port-read
// RAM. Issue a request with start while busy is low; exactly one result pulses
// on done per request, and the receiver must take it in that cycle. Extract
// sinks the entry level by level (two RAM reads per level, one per child, then
// a compare and write-back). Decrease key scans the slots in a linear id search,
// then sifts up one level at a time. Build runs a sift-down from each internal
// node. The RAM has a single read port, and that read is registered. No clearing
// after reset.
module binary_min_heap_priority_queue
	import bmh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          command,
	input  logic [ID_BITS-1:0]  node_id,
	input  logic [31:0]         key,
	output logic                done,
	output logic [ID_BITS-1:0]  out_node,
	output logic [31:0]         out_key,
	output logic [1:0]          status
);

	state_t state_q, state_n;
	logic [CNT_BITS-1:0] count_q;
	logic [CNT_BITS-1:0] pos_q;
	logic [CNT_BITS-1:0] bidx_q;
	logic [CNT_BITS-1:0] scan_q;
	logic building_q;
	logic [ID_BITS-1:0] id_q;
	logic [KEY_BITS-1:0] key_q;
	entry_t cur_q, lft_q, res_q;
	logic has_l_q;
	logic [1:0] status_q;

	logic we;
	logic [ADDR_BITS-1:0] waddr, raddr;
	entry_t wdata, rdata;

	bmh_ram #(.DEPTH(CAPACITY), .WIDTH(ENTRY_BITS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [CNT_BITS:0] lc, rc, upi;
	assign lc  = {pos_q, 1'b1};
	assign rc  = {pos_q, 1'b0} + (CNT_BITS+1)'(2);
	assign upi = {1'b0, pos_q} - (CNT_BITS+1)'(1);

	logic l_ok, r_ok, l_win, r_win;
	assign l_ok  = lc < {1'b0, count_q};
	assign r_ok  = rc < {1'b0, count_q};
	assign l_win = has_l_q && (lft_q.key < cur_q.key);
	// right child compared against the best so far
	assign r_win = r_ok && (rdata.key < (l_win ? lft_q.key : cur_q.key));

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				unique case (cmd_t'(command))
					CMD_LOAD: state_n = S_DONE;
					CMD_BUILD: state_n = (count_q < CNT_BITS'(2)) ? S_DONE : S_BUILD_NEXT;
					CMD_DECREASE: state_n = (count_q == '0) ? S_DONE : S_SEARCH;
					default: state_n = (count_q == '0) ? S_DONE : S_EXT_RD;
				endcase
			end
			S_SEARCH: state_n = S_SEARCH_CHK;
			S_SEARCH_CHK: begin
				if (rdata.id == id_q) state_n = S_UP_RD;
				else if (scan_q + CNT_BITS'(1) >= count_q) state_n = S_DONE;
				else state_n = S_SEARCH;
			end
			S_UP_RD: state_n = (pos_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP: state_n = (cur_q.key < rdata.key) ? S_UP_RD : S_DONE;
			S_EXT_RD: state_n = S_EXT_WR;
			S_EXT_WR: state_n = S_DN_RD_L;
			S_DN_RD_L: state_n = S_DN_RD_R;
			S_DN_RD_R: state_n = S_DN_CMP;
			S_DN_CMP: begin
				if (l_win || r_win) state_n = S_DN_RD_L;
				else if (building_q) state_n = S_BUILD_NEXT;
				else state_n = S_DONE;
			end
			S_BUILD_NEXT: state_n = (bidx_q == '0) ? S_DONE : S_BUILD_LD;
			S_BUILD_LD: state_n = S_DN_RD_R;
			S_DONE: state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = cur_q;
		raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				waddr = count_q[ADDR_BITS-1:0];
				wdata.id = node_id;
				wdata.key = KEY_BITS'(key);
				we = start && (cmd_t'(command) == CMD_LOAD) &&
					(count_q < CNT_BITS'(CAPACITY));
				raddr = '0;
			end
			S_SEARCH: raddr = scan_q[ADDR_BITS-1:0];
			S_UP_RD: begin
				raddr = upi[ADDR_BITS:1];
			end
			S_UP_CMP: begin
				// swap with parent: parent entry moves down
				we = cur_q.key < rdata.key;
				waddr = pos_q[ADDR_BITS-1:0];
				wdata = rdata;
			end
			S_EXT_RD: raddr = ADDR_BITS'(count_q - CNT_BITS'(1));
			S_EXT_WR: begin
				we = 1'b1;
				waddr = '0;
				wdata = rdata;
			end
			S_DN_RD_L: raddr = lc[ADDR_BITS-1:0];
			S_DN_RD_R: raddr = rc[ADDR_BITS-1:0];
			S_DN_CMP: begin
				we = l_win || r_win;
				waddr = pos_q[ADDR_BITS-1:0];
				wdata = r_win ? rdata : lft_q;
			end
			S_BUILD_NEXT: raddr = ADDR_BITS'(bidx_q - CNT_BITS'(1));
			S_BUILD_LD: raddr = lc[ADDR_BITS-1:0];
			default: ;
		endcase
		// the final slot receives the sifted entry
		if (state_q == S_DN_CMP && !(l_win || r_win)) begin
			we = 1'b1;
			waddr = pos_q[ADDR_BITS-1:0];
			wdata = cur_q;
		end
		if (state_q == S_UP_CMP && !(cur_q.key < rdata.key)) begin
			we = 1'b1;
			waddr = pos_q[ADDR_BITS-1:0];
			wdata = cur_q;
		end
		if (state_q == S_UP_RD && pos_q == '0) begin
			we = 1'b1;
			waddr = '0;
			wdata = cur_q;
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			building_q <= 1'b0;
		end else begin
			state_q <= state_n;
			unique case (state_q)
				S_IDLE: if (start) begin
					id_q <= node_id;
					key_q <= KEY_BITS'(key);
					res_q <= '0;
					status_q <= ST_OK;
					scan_q <= '0;
					building_q <= 1'b0;
					unique case (cmd_t'(command))
						CMD_LOAD: begin
							if (count_q < CNT_BITS'(CAPACITY)) count_q <= count_q + CNT_BITS'(1);
							else status_q <= ST_FULL;
						end
						CMD_BUILD: begin
							bidx_q <= count_q >> 1;
							building_q <= 1'b1;
						end
						CMD_DECREASE: if (count_q == '0) status_q <= ST_NOT_FOUND;
						default: if (count_q == '0) status_q <= ST_EMPTY;
					endcase
				end
				S_SEARCH_CHK: begin
					if (rdata.id == id_q) begin
						pos_q <= scan_q;
						cur_q.id <= rdata.id;
						cur_q.key <= key_q;
					end else if (scan_q + CNT_BITS'(1) >= count_q) begin
						status_q <= ST_NOT_FOUND;
					end
					scan_q <= scan_q + CNT_BITS'(1);
				end
				S_UP_CMP: if (cur_q.key < rdata.key) pos_q <= upi[CNT_BITS:1];
				S_EXT_RD: begin
					res_q <= rdata;
					count_q <= count_q - CNT_BITS'(1);
					pos_q <= '0;
				end
				S_EXT_WR: cur_q <= rdata;
				// hold the left child for the compare
				S_DN_RD_R: begin
					lft_q <= rdata;
					has_l_q <= l_ok;
				end
				S_DN_CMP: begin
					if (r_win) pos_q <= rc[CNT_BITS-1:0];
					else if (l_win) pos_q <= lc[CNT_BITS-1:0];
				end
				S_BUILD_NEXT: if (bidx_q != '0) begin
					bidx_q <= bidx_q - CNT_BITS'(1);
					pos_q <= bidx_q - CNT_BITS'(1);
				end
				// load the entry that starts this sift-down
				S_BUILD_LD: cur_q <= rdata;
				default: ;
			endcase
		end
	end

	// result outputs
	always_comb begin
		busy = state_q != S_IDLE;
		done = state_q == S_DONE;
		out_node = (status_q == ST_OK) ? res_q.id : '0;
		out_key = (status_q == ST_OK) ? 32'(res_q.key) : '0;
		status = status_q;
	end

endmodule

// ===== hdl/bmh_ram.sv =====
module bmh_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bmh_checker.sv =====
module bmh_checker
	import bmh_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [15:0] out_node,
	input logic [31:0] out_key
);

	// a request raises busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");

	// done ends the busy period
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");

	// done only while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");

	// failed requests return zero payload
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> out_node == '0 && out_key == '0)
		else $error("payload on failure");

endmodule

bind binary_min_heap_priority_queue bmh_checker u_bmh_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .out_node(out_node), .out_key(out_key)
);
